[rtl/multi_timer_bank_defines.svh]
// assertion macros for the timer bank
`ifndef MULTI_TIMER_BANK_DEFINES_SVH
`define MULTI_TIMER_BANK_DEFINES_SVH

// same-cycle implication, reset disables the check
`define MTB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// next-cycle implication, reset disables the check
`define MTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

[rtl/mtb_pkg.sv]
// shared types and constants of the timer bank
package mtb_pkg;

  localparam int OP_W            = 3;
  localparam int ID_W            = 3;
  localparam int PERIOD_W        = 32;
  localparam int TIMER_COUNT_DEF = 8;

  typedef enum logic [OP_W-1:0] {
    OP_START_ONCE = 3'd0,
    OP_START_AUTO = 3'd1,
    OP_STOP       = 3'd2,
    OP_CHECK      = 3'd3,
    OP_TICK       = 3'd4
  } op_t;

  typedef struct packed {
    logic op_apply;
    logic rd_en;
    logic out_load;
  } cmd_t;

endpackage

[rtl/multi_timer_bank.sv]
// Bank of TIMER_COUNT down-counting timers driven by one operation per input
// transaction: start once, start auto-reload, stop, check-and-clear, tick.
// Every transaction gives exactly one result transaction; expired is the
// cleared flag for a check and 0 otherwise. A start, stop or check moves
// from acceptance to the hold state, which loads the output register, and
// the input is free again in the cycle after that load. A tick walks the
// count memory through its single read port, one timer per cycle with the
// write-back in the cycle after each read, then passes through the drain
// and hold states before the output register loads; the input is stalled
// meanwhile. A new transaction is taken while the previous result still
// waits in the output register; the result load, and the stall of the
// input, then last until that earlier result is taken.
`include "multi_timer_bank_defines.svh"

module multi_timer_bank #(
  parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mtb_pkg::OP_W-1:0]      in_op,
  input  logic [mtb_pkg::ID_W-1:0]      in_timer_id,
  input  logic [mtb_pkg::PERIOD_W-1:0]  in_period,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_expired
);

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  mtb_pkg::cmd_t    cmd;
  logic [IDX_W-1:0] rd_idx;

  mtb_ctrl #(
    .TIMER_COUNT(TIMER_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .rd_idx   (rd_idx)
  );

  mtb_dp #(
    .TIMER_COUNT(TIMER_COUNT),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_idx     (rd_idx),
    .in_op      (in_op),
    .in_timer_id(in_timer_id),
    .in_period  (in_period),
    .out_expired(out_expired)
  );

  `MTB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `MTB_ASSERT_NOW(a_sweep_only_busy, cmd.rd_en, in_stall && !cmd.op_apply)
  `MTB_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, out_valid)
  `MTB_ASSERT_NEXT(a_tick_starts_sweep,
    in_valid && !in_stall && (in_op == mtb_pkg::OP_TICK), cmd.rd_en)

endmodule

[rtl/mtb_dp.sv]
// timer bank datapath: count memory, flags, result and output registers
module mtb_dp #(
  parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF,
  parameter int IDX_W       = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtb_pkg::cmd_t                 cmd,
  input  logic [IDX_W-1:0]              rd_idx,
  input  logic [mtb_pkg::OP_W-1:0]      in_op,
  input  logic [mtb_pkg::ID_W-1:0]      in_timer_id,
  input  logic [mtb_pkg::PERIOD_W-1:0]  in_period,
  output logic                          out_expired
);

  localparam int PW = mtb_pkg::PERIOD_W;

  // entry holds {reload, remaining}
  logic [2*PW-1:0]        mem [TIMER_COUNT];
  logic [2*PW-1:0]        mem_q_r;
  logic                   wb_en_r;
  logic [IDX_W-1:0]       wb_idx_r;
  logic [TIMER_COUNT-1:0] rem_vld_r;
  logic [TIMER_COUNT-1:0] mark_r;
  logic [TIMER_COUNT-1:0] auto_r;
  logic                   res_r;
  logic                   out_expired_r;

  mtb_pkg::op_t           op;
  logic [IDX_W+2:0]       id_ext;
  logic [IDX_W-1:0]       idx;
  logic                   id_ok;
  logic                   is_start;

  logic [PW-1:0]          rem_cur;
  logic [PW-1:0]          rem_dec;
  logic [PW-1:0]          rem_new;
  logic                   hit;
  logic                   expire;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [2*PW-1:0]        mem_wdata;

  assign op       = mtb_pkg::op_t'(in_op);
  assign id_ext   = (IDX_W+3)'(in_timer_id);
  assign idx      = id_ext[IDX_W-1:0];
  assign id_ok    = 32'(in_timer_id) < 32'(TIMER_COUNT);
  assign is_start = (op == mtb_pkg::OP_START_ONCE) || (op == mtb_pkg::OP_START_AUTO);

  // write-back of one timer during a tick sweep
  always_comb begin
    rem_cur = rem_vld_r[wb_idx_r] ? mem_q_r[PW-1:0] : '0;
    rem_dec = rem_cur - PW'(1);
    hit     = rem_cur != '0;
    expire  = hit && (rem_dec == '0);
    rem_new = expire ? (auto_r[wb_idx_r] ? mem_q_r[2*PW-1:PW] : '0) : rem_dec;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wb_idx_r;
    mem_wdata = {mem_q_r[2*PW-1:PW], rem_new};
    if (wb_en_r && hit) begin
      mem_we = 1'b1;
    end else if (cmd.op_apply && is_start && id_ok) begin
      mem_we    = 1'b1;
      mem_waddr = idx;
      mem_wdata = {in_period, in_period};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_idx];
    end
    if (cmd.op_apply) begin
      res_r <= (op == mtb_pkg::OP_CHECK) && id_ok && mark_r[idx];
    end
    if (cmd.out_load) begin
      out_expired_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_en_r   <= 1'b0;
      wb_idx_r  <= '0;
      rem_vld_r <= '0;
      mark_r    <= '0;
      auto_r    <= '0;
    end else begin
      wb_en_r <= cmd.rd_en;
      if (cmd.rd_en) begin
        wb_idx_r <= rd_idx;
      end
      if (wb_en_r && expire) begin
        mark_r[wb_idx_r] <= 1'b1;
      end
      if (cmd.op_apply && id_ok) begin
        unique case (op)
          mtb_pkg::OP_START_ONCE, mtb_pkg::OP_START_AUTO: begin
            rem_vld_r[idx] <= 1'b1;
            mark_r[idx]    <= 1'b0;
            auto_r[idx]    <= (op == mtb_pkg::OP_START_AUTO);
          end
          mtb_pkg::OP_STOP: begin
            rem_vld_r[idx] <= 1'b0;
            mark_r[idx]    <= 1'b0;
            auto_r[idx]    <= 1'b0;
          end
          mtb_pkg::OP_CHECK: begin
            mark_r[idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_expired = out_expired_r;

endmodule

[rtl/mtb_ctrl.sv]
// timer bank controller: handshakes, tick sweep sequencing, output valid
module mtb_ctrl #(
  parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF,
  parameter int IDX_W       = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [mtb_pkg::OP_W-1:0]  in_op,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mtb_pkg::cmd_t             cmd,
  output logic [IDX_W-1:0]          rd_idx
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

  state_t           state_r;
  logic [IDX_W-1:0] cnt_r;
  logic             out_vld_r;
  logic             accept;
  logic             out_free;

  assign in_stall = state_r != ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  assign cmd.op_apply = accept;
  assign cmd.rd_en    = state_r == ST_SWEEP;
  assign cmd.out_load = (state_r == ST_HOLD) && out_free;
  assign rd_idx       = cnt_r;
  assign out_valid    = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            state_r <= (mtb_pkg::op_t'(in_op) == mtb_pkg::OP_TICK) ? ST_SWEEP : ST_HOLD;
          end
        end
        ST_SWEEP: begin
          if (cnt_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
